@@ rtl/npct_pkg.sv @@
// Package for the neighbour packet count table: transfer payload types,
// result status codes, table entry layout and the reset value of the register.
// No dependencies.
`default_nettype none

package npct_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam logic [15:0] PPN_RESET = 16'd100;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_READ_OK  = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [15:0] source_id;
    logic [15:0] seq_num;
    logic [5:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] entry_id;
    logic [15:0] times_received;
    logic [15:0] valid_received;
    logic [15:0] missed_count;
    logic [6:0]  entries_used;
  } rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] rx;
    logic [15:0] valid;
  } entry_t;

  // Saturating increment of a 16-bit counter.
  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

@@ rtl/neighbor_packet_count_table.sv @@
// Neighbour packet count table: top level with the entry memory, the search
// sequencer and the response register.
// Depends on npct_pkg.
//
// Request channel (req_valid / req_ready / req): a transfer carries a record
// command, which logs a packet from req.source_id with sequence number
// req.seq_num, or a read command, which returns the entry at req.read_index.
// Response channel (rsp_valid / rsp_ready / rsp): one transfer per request, in
// order. cfg_we writes cfg_data into packets_per_node on that edge, and must
// only be used while the block is idle.
// A record command scans the stored IDs one per cycle through the registered
// read port of the entry memory with one shared comparator. A hit goes on
// through S_UPDATE, which writes the new counts, to S_FINISH, which loads the
// response; a miss goes straight from S_SCAN to S_FINISH. A read of an occupied
// index passes through S_LOAD, a read of an unoccupied one goes straight to
// S_FINISH. req_ready is low from acceptance until the response has been loaded,
// so the next request transfer comes in the cycle after that at the earliest.
// Reset empties the table and sets packets_per_node to 100. A stalled response
// is held in its register; the next request is still processed and waits only
// for that register.
`default_nettype none

module neighbor_packet_count_table
  import npct_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output rsp_t             rsp,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > 6) ? CW : 6;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_UPDATE = 5'b00100,
    S_LOAD   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  // Control registers.
  state_t          state, state_next;
  logic [CW-1:0]   fill, fill_next;
  logic [CW-1:0]   ptr, ptr_next;
  logic            cmp_vld, cmp_vld_next;
  logic [15:0]     ppn;

  // Working registers of the request in flight.
  logic [15:0]     src, src_next;
  logic            in_range, in_range_next;
  logic [IW-1:0]   cmp_ptr, cmp_ptr_next;
  logic [IW-1:0]   hit_ptr, hit_ptr_next;
  entry_t          ent, ent_next;
  logic [2:0]      status, status_next;
  logic            has_entry, has_entry_next;
  rsp_t            rsp_next;
  logic            rsp_load;

  // Entry memory: one write port, one registered read port.
  entry_t          mem [TABLE_DEPTH];
  entry_t          rd_data;
  logic [IW-1:0]   raddr;
  logic            we;
  logic [IW-1:0]   waddr;
  entry_t          wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  assign req_ready = (state == S_IDLE) && !rst;

  // Shared comparator of the scan: stored ID against the source ID.
  logic id_match;
  assign id_match = cmp_vld && (rd_data.id == src);

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    ptr_next       = ptr;
    cmp_vld_next   = 1'b0;
    cmp_ptr_next   = cmp_ptr;
    hit_ptr_next   = hit_ptr;
    src_next       = src;
    in_range_next  = in_range;
    ent_next       = ent;
    status_next    = status;
    has_entry_next = has_entry;
    raddr          = IW'(req.read_index);
    we             = 1'b0;
    waddr          = hit_ptr;
    wdata          = ent;
    rsp_load       = 1'b0;
    rsp_next       = rsp;

    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          src_next      = req.source_id;
          in_range_next = (req.seq_num < ppn);
          ptr_next      = '0;
          if (req.cmd == CMD_READ) begin
            if (XW'(req.read_index) < XW'(fill)) begin
              // The read was issued this cycle at the request's index.
              status_next    = ST_READ_OK;
              has_entry_next = 1'b1;
              state_next     = S_LOAD;
            end else begin
              status_next    = ST_EMPTY;
              has_entry_next = 1'b0;
              ent_next       = '0;
              state_next     = S_FINISH;
            end
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        raddr = ptr[IW-1:0];
        if (id_match) begin
          ent_next     = rd_data;
          hit_ptr_next = cmp_ptr;
          state_next   = S_UPDATE;
        end else if (ptr < fill) begin
          ptr_next     = ptr + CW'(1);
          cmp_vld_next = 1'b1;
          cmp_ptr_next = ptr[IW-1:0];
        end else if (!cmp_vld) begin
          // Every stored ID has been compared without a hit.
          if (fill == CW'(TABLE_DEPTH)) begin
            status_next    = ST_FULL;
            has_entry_next = 1'b0;
            ent_next       = '{id: src, rx: 16'd0, valid: 16'd0};
          end else begin
            status_next    = ST_INSERTED;
            has_entry_next = 1'b1;
            ent_next       = '{id: src, rx: 16'd1, valid: {15'd0, in_range}};
            we             = 1'b1;
            waddr          = fill[IW-1:0];
            wdata          = ent_next;
            fill_next      = fill + CW'(1);
          end
          state_next = S_FINISH;
        end
      end

      S_UPDATE: begin
        ent_next.rx    = sat_inc(ent.rx);
        ent_next.valid = in_range ? sat_inc(ent.valid) : ent.valid;
        we             = 1'b1;
        waddr          = hit_ptr;
        wdata          = ent_next;
        status_next    = ST_UPDATED;
        has_entry_next = 1'b1;
        state_next     = S_FINISH;
      end

      S_LOAD: begin
        ent_next   = rd_data;
        state_next = S_FINISH;
      end

      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load                = 1'b1;
          rsp_next.status         = status;
          rsp_next.entry_id       = ent.id;
          rsp_next.times_received = ent.rx;
          rsp_next.valid_received = ent.valid;
          rsp_next.missed_count   = (has_entry && (ppn > ent.valid)) ? ppn - ent.valid
                                                                     : 16'd0;
          rsp_next.entries_used   = 7'(fill);
          state_next              = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      ptr       <= '0;
      cmp_vld   <= 1'b0;
      ppn       <= PPN_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      ptr     <= ptr_next;
      cmp_vld <= cmp_vld_next;
      if (cfg_we) begin
        ppn <= cfg_data;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    src       <= src_next;
    in_range  <= in_range_next;
    cmp_ptr   <= cmp_ptr_next;
    hit_ptr   <= hit_ptr_next;
    ent       <= ent_next;
    status    <= status_next;
    has_entry <= has_entry_next;
    rsp       <= rsp_next;
  end

endmodule

`default_nettype wire

@@ rtl/npct_checker.sv @@
// Port-level checker for the neighbour packet count table, bound to the top.
// Depends on npct_pkg and neighbor_packet_count_table.
`default_nettype none

module npct_checker
  import npct_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp
);

  // A response that is not taken is held unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // One request at a time: acceptance closes the request channel.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in flight");

  // Dropped senders and empty reads carry no counts.
  a_no_entry_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_EMPTY) |->
      rsp.times_received == 16'd0 && rsp.valid_received == 16'd0 &&
      rsp.missed_count == 16'd0)
    else $error("counts reported without an entry");

  // A new sender has exactly one reception.
  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_INSERTED |->
      rsp.times_received == 16'd1 && rsp.valid_received <= 16'd1)
    else $error("inserted entry has wrong counts");

  // The valid count never overtakes the reception count.
  a_valid_le_rx: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.valid_received <= rsp.times_received)
    else $error("valid count exceeds reception count");

endmodule

bind neighbor_packet_count_table npct_checker u_npct_checker (.*);

`default_nettype wire

@@ tb/neighbor_packet_count_table_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for neighbor_packet_count_table: drives record and read
// transfers through the valid/ready channels and checks every response against a
// predictor of the sender table. Depends on npct_pkg and the RTL of the block.

module neighbor_packet_count_table_tb;
  import npct_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  // This bound lies far above what a healthy run needs, even with every request
  // scanning a full table under stalls, so it only trips on a hang.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 300;
  // A systematic fault would otherwise flood the log.
  localparam int MAX_REPORTS = 100;

  // Predictor of the sender table together with the queue of responses that are
  // still to come back. The table copy is updated when a request transfer is
  // accepted, so each queued response reflects the state at that moment.
  class count_table_checker;
    logic [15:0] sender_id   [DEPTH];
    logic [15:0] rx_total    [DEPTH];
    logic [15:0] valid_total [DEPTH];
    int unsigned fill;
    logic [15:0] ppn;
    rsp_t        awaited_rsp [$];
    int unsigned errors;

    function new();
      fill = 0;
      ppn = PPN_RESET;
      errors = 0;
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Appends a response to the tail of the queue of awaited responses.
    function void queue_rsp(rsp_t r);
      awaited_rsp = {awaited_rsp, r};
    endfunction

    function rsp_t entry_rsp(logic [2:0] st, int slot);
      rsp_t r;
      r.status         = st;
      r.entry_id       = sender_id[slot];
      r.times_received = rx_total[slot];
      r.valid_received = valid_total[slot];
      r.missed_count   = (ppn > valid_total[slot]) ? ppn - valid_total[slot] : 16'd0;
      r.entries_used   = 7'(fill);
      return r;
    endfunction

    // Responses that carry no table entry: a dropped sender or an empty slot.
    function rsp_t bare_rsp(logic [2:0] st, logic [15:0] id);
      rsp_t r;
      r = '0;
      r.status       = st;
      r.entry_id     = id;
      r.entries_used = 7'(fill);
      return r;
    endfunction

    function void note_request(req_t r);
      int slot;
      bit in_range;
      slot = -1;
      in_range = (r.seq_num < ppn);
      if (r.cmd == CMD_READ) begin
        if (r.read_index < fill) begin
          queue_rsp(entry_rsp(ST_READ_OK, r.read_index));
        end else begin
          queue_rsp(bare_rsp(ST_EMPTY, 16'd0));
        end
      end else begin
        for (int i = 0; i < fill; i++) begin
          if (sender_id[i] == r.source_id) slot = i;
        end
        if (slot >= 0) begin
          rx_total[slot] = bump(rx_total[slot]);
          if (in_range) valid_total[slot] = bump(valid_total[slot]);
          queue_rsp(entry_rsp(ST_UPDATED, slot));
        end else if (fill >= DEPTH) begin
          queue_rsp(bare_rsp(ST_FULL, r.source_id));
        end else begin
          sender_id[fill]   = r.source_id;
          rx_total[fill]    = 16'd1;
          valid_total[fill] = in_range ? 16'd1 : 16'd0;
          fill++;
          queue_rsp(entry_rsp(ST_INSERTED, fill - 1));
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (awaited_rsp.size() == 0) begin
        report($sformatf("response 0x%0h arrived with nothing outstanding", got));
      end else begin
        want = awaited_rsp.pop_front();
        compare_field("status", got.status, want.status);
        compare_field("entry_id", got.entry_id, want.entry_id);
        compare_field("times_received", got.times_received, want.times_received);
        compare_field("valid_received", got.valid_received, want.valid_received);
        compare_field("missed_count", got.missed_count, want.missed_count);
        compare_field("entries_used", got.entries_used, want.entries_used);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = 16'd0;

  // The receiver walks round a 16-bit pattern, one bit per cycle; a phase
  // without back-pressure simply loads all ones.
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  ready_phase = 4'd0;
  bit          send_gaps = 1'b1;
  int unsigned cycles = 0;
  // Every source ID that has been offered in a record, so that later records
  // can hit stored senders (or senders that were dropped once the table filled).
  logic [15:0] known_ids [$];

  count_table_checker table_check = new();

  neighbor_packet_count_table uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_ready <= ready_pattern[ready_phase];
    ready_phase <= ready_phase + 4'd1;
  end

  // Both channels are observed at the rising edge, where a transfer takes place.
  // A response can never belong to the request accepted on the same edge, so the
  // order of the two calls does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) table_check.check_response(rsp);
      if (req_valid && req_ready) table_check.note_request(req);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The sender tasks all start and end just after a falling edge. Valid stays
  // high from one transfer to the next unless a pause is taken in between.
  task automatic send_request(req_t item);
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender(int unsigned n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Every request yields exactly one response, so once the queue is empty the
  // block is idle.
  task automatic drain();
    req_valid <= 1'b0;
    while (table_check.awaited_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic set_packets_per_node(logic [15:0] value);
    drain();
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    table_check.ppn = value;
  endtask

  task automatic start_phase(logic [15:0] ppn_value, bit stalls, bit gaps);
    set_packets_per_node(ppn_value);
    ready_pattern <= stalls ? (16'($urandom) | 16'h0001) : 16'hFFFF;
    send_gaps = gaps;
  endtask

  // The fields that a command ignores are filled with noise.
  function automatic req_t record_of(logic [15:0] id, logic [15:0] seq);
    req_t r;
    r.cmd        = CMD_RECORD;
    r.source_id  = id;
    r.seq_num    = seq;
    r.read_index = 6'($urandom);
    return r;
  endfunction

  function automatic req_t read_of(logic [5:0] idx);
    req_t r;
    r.cmd        = CMD_READ;
    r.source_id  = 16'($urandom);
    r.seq_num    = 16'($urandom);
    r.read_index = idx;
    return r;
  endfunction

  // Half of the sequence numbers sit right at the valid/invalid boundary; the
  // sum wraps on purpose when the setting is at either end of its range.
  function automatic logic [15:0] pick_seq();
    int unsigned ppn;
    ppn = table_check.ppn;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 15));
      default: return 16'(ppn + $urandom_range(0, 3) - 2);
    endcase
  endfunction

  // Mostly records from senders already seen, some from new senders and some
  // reads, which mainly target occupied slots.
  function automatic req_t pick_request();
    int unsigned roll;
    int unsigned span;
    logic [15:0] id;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      span = (table_check.fill == 0) ? 1 : table_check.fill;
      if ($urandom_range(0, 3) == 0) return read_of(6'($urandom));
      return read_of(6'($urandom_range(0, span - 1)));
    end
    if (roll < 32 || known_ids.size() == 0) begin
      id = 16'($urandom);
      known_ids = {known_ids, id};
    end else begin
      id = known_ids[$urandom_range(0, known_ids.size() - 1)];
    end
    return record_of(id, pick_seq());
  endfunction

  task automatic run_traffic(int unsigned count);
    int unsigned burst;
    burst = 0;
    repeat (count) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if (send_gaps) pause_sender($urandom_range(0, 7));
      end
      send_request(pick_request());
      burst--;
    end
  endtask

  initial begin
    logic [15:0] ppn_values [6];
    ppn_values = '{16'd0, 16'd1, 16'hFFFF, 16'($urandom), 16'd100,
                   16'($urandom_range(2, 300))};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, run with the reset value of the register (100). Reads of
    // an empty table come first, then inserts and updates at the extremes of the
    // IDs and on both sides of the sequence number limit, then reads once more.
    send_request(read_of(6'd0));
    send_request(read_of(6'd63));
    send_request(record_of(16'h0000, 16'h0000));
    send_request(record_of(16'hFFFF, 16'hFFFF));
    send_request(record_of(16'h0000, 16'd99));
    send_request(record_of(16'h0000, 16'd100));
    send_request(record_of(16'hFFFF, 16'd99));
    send_request(record_of(16'h5A5A, 16'hA5A5));
    send_request(read_of(6'd0));
    send_request(read_of(6'd1));
    send_request(read_of(6'd2));
    send_request(read_of(6'd3));
    send_request(read_of(6'd63));
    known_ids = '{16'h0000, 16'hFFFF, 16'h5A5A};

    // Random phases, each with its own register value and idling style. The
    // table fills up part-way through, after which new senders are dropped.
    foreach (ppn_values[p]) begin
      start_phase(ppn_values[p], (p % 3) != 2, (p % 2) == 0);
      run_traffic(PHASE_ITEMS);
    end

    drain();
    repeat (DEPTH + 10) @(negedge clk);
    if (table_check.awaited_rsp.size() != 0) begin
      table_check.report("responses still outstanding at the end of the run");
    end
    if (table_check.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
